// ===== hw/rtl/sacl_pkg.sv =====
package sacl_pkg;

   // fixed field widths
   localparam int ADDR_W     = 48;
   localparam int TAG_W      = 48;
   localparam int AGE_W      = 64;
   localparam int CNT_W      = 32;
   localparam int REQ_W      = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   // default geometry
   localparam int NUM_WAYS_DEF     = 4;
   localparam int MAX_SET_BITS_DEF = 6;

   // age value of a freshly filled line, and the bit set on a hit
   localparam logic [AGE_W-1:0] AGE_TOP = {1'b1, {(AGE_W-1){1'b0}}};

   // access kinds
   localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_STORE  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_MODIFY = 2'd2;
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

   // control register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS       = 2'd2;

   // control register reset values
   localparam logic [2:0] SET_BITS_RST   = 3'd4;
   localparam logic [5:0] BLOCK_BITS_RST = 6'd4;
   localparam logic [2:0] WAYS_RST       = 3'd4;

   // one way of a set
   typedef struct packed {
      logic             valid;
      logic [TAG_W-1:0] tag;
      logic [AGE_W-1:0] age;
   } sacl_line_type;

   localparam int LINE_W = 1 + TAG_W + AGE_W;

   // lookup outcome handed from the set update logic to the control
   typedef struct packed {
      logic hit;
      logic miss;
      logic evict;
   } sacl_status_type;

endpackage

// ===== hw/rtl/sacl_intf.sv =====
// access request channel
interface sacl_req_if;
   logic                         valid;
   logic                         ready;
   logic [sacl_pkg::REQ_W-1:0]   req_type;
   logic [sacl_pkg::ADDR_W-1:0]  address;

   modport source (output valid, req_type, address, input ready);
   modport sink   (input valid, req_type, address, output ready);
endinterface

// access result channel
interface sacl_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         was_hit;
   logic                         was_miss;
   logic                         was_eviction;
   logic                         extra_hit;
   logic [sacl_pkg::CNT_W-1:0]   total_hits;
   logic [sacl_pkg::CNT_W-1:0]   total_misses;
   logic [sacl_pkg::CNT_W-1:0]   total_evictions;

   modport source (output valid, was_hit, was_miss, was_eviction, extra_hit,
                   total_hits, total_misses, total_evictions, input ready);
   modport sink   (input valid, was_hit, was_miss, was_eviction, extra_hit,
                   total_hits, total_misses, total_evictions, output ready);
endinterface

// control register write channel
interface sacl_csr_if;
   logic                             valid;
   logic                             ready;
   logic [sacl_pkg::CSR_IDX_W-1:0]   index;
   logic [sacl_pkg::CSR_DATA_W-1:0]  wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== hw/rtl/set_assoc_cache_aging_lru.sv =====
// Set-associative cache tag model with aging-counter replacement. Each request
// beat is one load, store or modify to a 48-bit address and yields exactly one
// response beat with the hit/miss/eviction flags and the running totals (an
// unused kind only gets clear flags). All tags, valid bits and 64-bit ages of a
// set sit in one word of a synchronous memory: the accepting cycle issues the
// set read, the next cycle ages the ways and picks the victim, and the word is
// written back once the response register can take the result; a new request
// is taken in the cycle after the write-back. A result still waiting on the
// response side does not block acceptance; only the write-back waits for the
// response register to drain. After reset a clearing pass writes each of
// the 2**MAX_SET_BITS sets (64 by default) once, taking no request meanwhile;
// control register writes are always taken and must only happen while the block is idle.
module set_assoc_cache_aging_lru #(
   parameter int NUM_WAYS     = sacl_pkg::NUM_WAYS_DEF,
   parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   sacl_req_if.sink   req_chan,
   sacl_rsp_if.source rsp_chan,
   sacl_csr_if.sink   csr_chan
);

   localparam int DEPTH  = 2 ** MAX_SET_BITS;
   localparam int IDX_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int WCNT_W = $clog2(NUM_WAYS + 1);
   localparam int WORD_W = NUM_WAYS * sacl_pkg::LINE_W;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_LOOKUP = 2'd2;

   logic [1:0]                       state_ff, state_in;
   logic [IDX_W-1:0]                 clear_addr_ff, clear_addr_in;
   logic [2:0]                       set_bits_ff, set_bits_in;
   logic [5:0]                       block_bits_ff, block_bits_in;
   logic [2:0]                       ways_ff, ways_in;
   logic [IDX_W-1:0]                 set_ff, set_in;
   logic [sacl_pkg::TAG_W-1:0]       tag_ff, tag_in;
   logic [sacl_pkg::REQ_W-1:0]       kind_ff, kind_in;
   logic [sacl_pkg::CNT_W-1:0]       hits_ff, hits_in;
   logic [sacl_pkg::CNT_W-1:0]       misses_ff, misses_in;
   logic [sacl_pkg::CNT_W-1:0]       evicts_ff, evicts_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   sacl_pkg::sacl_status_type        rsp_flags_ff, rsp_flags_in;
   logic                             rsp_extra_ff, rsp_extra_in;

   logic                             req_fire;
   logic                             rsp_fire;
   logic                             csr_fire;
   logic                             done;
   logic                             active;
   logic [2:0]                       set_shift;
   logic [7:0]                       tag_shift;
   logic [sacl_pkg::ADDR_W-1:0]      addr_blk;
   logic [IDX_W-1:0]                 set_mask;
   logic [IDX_W-1:0]                 req_set;
   logic [WCNT_W-1:0]                ways_eff;
   logic [1:0]                       hit_inc;

   logic                             mem_wr_en;
   logic [IDX_W-1:0]                 mem_wr_addr;
   logic [WORD_W-1:0]                mem_wr_data;
   logic [WORD_W-1:0]                mem_rd_data;
   sacl_pkg::sacl_line_type [NUM_WAYS-1:0] lines_rd;
   sacl_pkg::sacl_line_type [NUM_WAYS-1:0] lines_wr;
   sacl_pkg::sacl_status_type        status;

   // handshakes
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign csr_fire = csr_chan.valid && csr_chan.ready;
   assign done     = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp_chan.ready);
   assign active   = (kind_ff != sacl_pkg::REQ_UNUSED);

   // geometry clamps
   assign set_shift = (int'(set_bits_ff) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits_ff;
   assign ways_eff  = (ways_ff == '0) ? WCNT_W'(1) :
                      (int'(ways_ff) > NUM_WAYS) ? WCNT_W'(NUM_WAYS) : WCNT_W'(ways_ff);

   // set index and tag of the incoming beat
   assign tag_shift = 8'(set_shift) + 8'(block_bits_ff);
   assign addr_blk  = req_chan.address >> block_bits_ff;
   assign set_mask  = ~({IDX_W{1'b1}} << set_shift);
   assign req_set   = addr_blk[IDX_W-1:0] & set_mask;

   // set store
   sacl_line_mem #(
      .DEPTH  (DEPTH),
      .IDX_W  (IDX_W),
      .WORD_W (WORD_W)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (req_set),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   assign lines_rd = mem_rd_data;

   // aging, lookup and victim choice
   sacl_set_update #(
      .NUM_WAYS (NUM_WAYS),
      .WAY_W    (WAY_W),
      .WCNT_W   (WCNT_W)
   ) u_set_update (
      .lines_in  (lines_rd),
      .tag_in    (tag_ff),
      .ways_in   (ways_eff),
      .lines_out (lines_wr),
      .status    (status)
   );

   // write-back or clearing sweep
   assign mem_wr_en   = (state_ff == ST_CLEAR) || (done && active);
   assign mem_wr_addr = (state_ff == ST_CLEAR) ? clear_addr_ff : set_ff;
   assign mem_wr_data = (state_ff == ST_CLEAR) ? '0 : WORD_W'(lines_wr);

   // control sequencing
   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == IDX_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // accepted beat
   assign set_in  = req_fire ? req_set : set_ff;
   assign tag_in  = req_fire ? (req_chan.address >> tag_shift) : tag_ff;
   assign kind_in = req_fire ? req_chan.req_type : kind_ff;

   // control registers
   always_comb begin
      set_bits_in   = set_bits_ff;
      block_bits_in = block_bits_ff;
      ways_in       = ways_ff;
      if (csr_fire) begin
         case (csr_chan.index)
            sacl_pkg::CSR_SET_BITS:   set_bits_in   = csr_chan.wdata[2:0];
            sacl_pkg::CSR_BLOCK_BITS: block_bits_in = csr_chan.wdata;
            sacl_pkg::CSR_WAYS:       ways_in       = csr_chan.wdata[2:0];
            default: ;
         endcase
      end
   end

   // running totals and result register
   assign hit_inc = {1'b0, status.hit} + {1'b0, kind_ff == sacl_pkg::REQ_MODIFY};

   always_comb begin
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      evicts_in    = evicts_ff;
      rsp_flags_in = rsp_flags_ff;
      rsp_extra_in = rsp_extra_ff;
      rsp_valid_in = rsp_fire ? 1'b0 : rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         if (active) begin
            hits_in      = hits_ff + sacl_pkg::CNT_W'(hit_inc);
            misses_in    = misses_ff + sacl_pkg::CNT_W'(status.miss);
            evicts_in    = evicts_ff + sacl_pkg::CNT_W'(status.evict);
            rsp_flags_in = status;
            rsp_extra_in = (kind_ff == sacl_pkg::REQ_MODIFY);
         end else begin
            rsp_flags_in = '0;
            rsp_extra_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         set_bits_ff   <= sacl_pkg::SET_BITS_RST;
         block_bits_ff <= sacl_pkg::BLOCK_BITS_RST;
         ways_ff       <= sacl_pkg::WAYS_RST;
         hits_ff       <= '0;
         misses_ff     <= '0;
         evicts_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         set_bits_ff   <= set_bits_in;
         block_bits_ff <= block_bits_in;
         ways_ff       <= ways_in;
         hits_ff       <= hits_in;
         misses_ff     <= misses_in;
         evicts_ff     <= evicts_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      set_ff       <= set_in;
      tag_ff       <= tag_in;
      kind_ff      <= kind_in;
      rsp_flags_ff <= rsp_flags_in;
      rsp_extra_ff <= rsp_extra_in;
   end

   // response outputs
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.was_hit         = rsp_flags_ff.hit;
   assign rsp_chan.was_miss        = rsp_flags_ff.miss;
   assign rsp_chan.was_eviction    = rsp_flags_ff.evict;
   assign rsp_chan.extra_hit       = rsp_extra_ff;
   assign rsp_chan.total_hits      = hits_ff;
   assign rsp_chan.total_misses    = misses_ff;
   assign rsp_chan.total_evictions = evicts_ff;

   // an accepted beat always goes to the lookup cycle
   a_accept_lookup: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_LOOKUP))
      else $error("accepted beat did not enter lookup");

   // a new result only follows a lookup
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_LOOKUP))
      else $error("result appeared without a lookup");

   // an eviction is always a miss, never a hit
   a_flag_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!(rsp_flags_ff.hit && rsp_flags_ff.miss)
                        && (!rsp_flags_ff.evict || rsp_flags_ff.miss)))
      else $error("inconsistent result flags");

   // the miss total moves only on a completed lookup
   a_miss_step: assert property (@(posedge clock) disable iff (reset)
      !done |=> (misses_ff == $past(misses_ff)))
      else $error("miss total changed outside a lookup");

   // no memory write while waiting for a request
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_wr_en)
      else $error("set store written while idle");

endmodule

// ===== hw/rtl/sacl_line_mem.sv =====
module sacl_line_mem #(
   parameter int DEPTH  = 64,
   parameter int IDX_W  = 6,
   parameter int WORD_W = 452
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [WORD_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  logic [WORD_W-1:0] wr_data
);

   logic [WORD_W-1:0] mem_ff [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   // one set per word, written whole
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/sacl_set_update.sv =====
module sacl_set_update #(
   parameter int NUM_WAYS = 4,
   parameter int WAY_W    = 2,
   parameter int WCNT_W   = 3
) (
   input  sacl_pkg::sacl_line_type [NUM_WAYS-1:0] lines_in,
   input  logic [sacl_pkg::TAG_W-1:0]             tag_in,
   input  logic [WCNT_W-1:0]                      ways_in,
   output sacl_pkg::sacl_line_type [NUM_WAYS-1:0] lines_out,
   output sacl_pkg::sacl_status_type              status
);

   localparam int LEAVES = 2 ** $clog2(NUM_WAYS);
   localparam int NODES  = 2 * LEAVES - 1;

   logic [NUM_WAYS-1:0]           in_use;
   logic [NUM_WAYS-1:0]           match;
   logic [NUM_WAYS-1:0]           free;
   sacl_pkg::sacl_line_type [NUM_WAYS-1:0] aged;
   logic                          any_hit;
   logic                          any_free;
   logic [WAY_W-1:0]              first_free;
   logic [WAY_W-1:0]              victim;

   logic [sacl_pkg::AGE_W-1:0]    node_age [NODES];
   logic [WAY_W-1:0]              node_idx [NODES];
   logic                          node_act [NODES];

   // age every live way, mark matching ones
   always_comb begin
      for (int w = 0; w < NUM_WAYS; w++) begin
         in_use[w] = WCNT_W'(w) < ways_in;
         match[w]  = in_use[w] && lines_in[w].valid && (lines_in[w].tag == tag_in);
         free[w]   = in_use[w] && !lines_in[w].valid;
         aged[w]   = lines_in[w];
         if (in_use[w] && lines_in[w].valid) begin
            aged[w].age = (lines_in[w].age >> 1) | (match[w] ? sacl_pkg::AGE_TOP : '0);
         end
      end
   end

   assign any_hit  = |match;
   assign any_free = |free;

   // lowest free way
   always_comb begin
      first_free = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (free[w]) begin
            first_free = WAY_W'(w);
         end
      end
   end

   // minimum age tree, lower index wins ties
   for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
      if (i < NUM_WAYS) begin : g_way
         assign node_age[LEAVES-1+i] = aged[i].age;
         assign node_act[LEAVES-1+i] = in_use[i];
      end else begin : g_pad
         assign node_age[LEAVES-1+i] = '0;
         assign node_act[LEAVES-1+i] = 1'b0;
      end
      assign node_idx[LEAVES-1+i] = WAY_W'(i);
   end

   for (genvar k = 0; k < LEAVES - 1; k++) begin : g_node
      logic take_left;
      assign take_left = node_act[2*k+1] &&
                         (!node_act[2*k+2] || (node_age[2*k+1] <= node_age[2*k+2]));
      assign node_age[k] = take_left ? node_age[2*k+1] : node_age[2*k+2];
      assign node_idx[k] = take_left ? node_idx[2*k+1] : node_idx[2*k+2];
      assign node_act[k] = node_act[2*k+1] || node_act[2*k+2];
   end

   assign victim = any_free ? first_free : node_idx[0];

   // fill the victim on a miss
   always_comb begin
      lines_out = aged;
      if (!any_hit) begin
         lines_out[victim].valid = 1'b1;
         lines_out[victim].tag   = tag_in;
         lines_out[victim].age   = sacl_pkg::AGE_TOP;
      end
   end

   assign status.hit   = any_hit;
   assign status.miss  = !any_hit;
   assign status.evict = !any_hit && !any_free;

endmodule

// ===== dv/sacl_tb_pkg.sv =====
package sacl_tb_pkg;
   import sacl_pkg::*;

   localparam int LINES = (1 << MAX_SET_BITS_DEF) * NUM_WAYS_DEF;

   // one response beat as the checker sees it
   typedef struct packed {
      logic             was_hit;
      logic             was_miss;
      logic             was_eviction;
      logic             extra_hit;
      logic [CNT_W-1:0] total_hits;
      logic [CNT_W-1:0] total_misses;
      logic [CNT_W-1:0] total_evictions;
   } access_outcome_t;

   // tag store shadow plus the queue of outcomes still owed by the block
   class access_scoreboard;
      logic [2:0]       geo_set_bits;
      logic [5:0]       geo_block_bits;
      logic [2:0]       geo_ways;
      logic             line_valid [LINES];
      logic [TAG_W-1:0] line_tag   [LINES];
      logic [AGE_W-1:0] line_age   [LINES];
      logic [CNT_W-1:0] hit_count;
      logic [CNT_W-1:0] miss_count;
      logic [CNT_W-1:0] eviction_count;
      access_outcome_t  owed_outcomes [$];
      int unsigned      errors;

      function new();
         geo_set_bits   = SET_BITS_RST;
         geo_block_bits = BLOCK_BITS_RST;
         geo_ways       = WAYS_RST;
         for (int i = 0; i < LINES; i++) begin
            line_valid[i] = 1'b0;
            line_tag[i]   = '0;
            line_age[i]   = '0;
         end
         hit_count      = '0;
         miss_count     = '0;
         eviction_count = '0;
         errors         = 0;
      endfunction

      // mirror of a control register write, unknown indexes dropped
      function void write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SET_BITS:   geo_set_bits   = data[2:0];
            CSR_BLOCK_BITS: geo_block_bits = data[5:0];
            CSR_WAYS:       geo_ways       = data[2:0];
            default: ;
         endcase
      endfunction

      function int unsigned outstanding();
         return owed_outcomes.size();
      endfunction

      // run one accepted access through the shadow and queue its outcome
      function void note_access(logic [REQ_W-1:0] kind, logic [ADDR_W-1:0] addr);
         access_outcome_t res;
         int unsigned     sb;
         int unsigned     bb;
         int unsigned     ways;
         int unsigned     base;
         int unsigned     victim;
         logic [63:0]     a64;
         logic [63:0]     set_idx;
         logic [63:0]     tag;
         logic [AGE_W-1:0] least;

         res  = '0;
         sb   = (geo_set_bits > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : geo_set_bits;
         bb   = geo_block_bits;
         ways = geo_ways;
         if (ways < 1) ways = 1;
         if (ways > NUM_WAYS_DEF) ways = NUM_WAYS_DEF;

         if (kind != REQ_UNUSED) begin
            // shifts of 64 or more yield zero
            a64     = {16'h0, addr};
            set_idx = (a64 >> bb) & ((64'd1 << sb) - 64'd1);
            tag     = a64 >> (sb + bb);
            base    = int'(set_idx[5:0]) * NUM_WAYS_DEF;

            // age every valid way, refresh all that match
            for (int w = 0; w < ways; w++) begin
               if (line_valid[base + w]) begin
                  line_age[base + w] = line_age[base + w] >> 1;
                  if (line_tag[base + w] == tag[TAG_W-1:0]) begin
                     line_age[base + w] = line_age[base + w] | AGE_TOP;
                     res.was_hit = 1'b1;
                  end
               end
            end

            if (res.was_hit) begin
               hit_count = hit_count + 1;
            end else begin
               res.was_miss = 1'b1;
               miss_count   = miss_count + 1;
               victim       = ways;
               for (int w = ways - 1; w >= 0; w--) begin
                  if (!line_valid[base + w]) victim = w;
               end
               // set full: lowest age goes, lower way wins a tie
               if (victim == ways) begin
                  res.was_eviction = 1'b1;
                  eviction_count   = eviction_count + 1;
                  victim           = 0;
                  least            = line_age[base];
                  for (int w = 1; w < ways; w++) begin
                     if (line_age[base + w] < least) begin
                        least  = line_age[base + w];
                        victim = w;
                     end
                  end
               end
               line_valid[base + victim] = 1'b1;
               line_tag[base + victim]   = tag[TAG_W-1:0];
               line_age[base + victim]   = AGE_TOP;
            end

            // store half of a modify always hits
            if (kind == REQ_MODIFY) begin
               res.extra_hit = 1'b1;
               hit_count     = hit_count + 1;
            end
         end

         res.total_hits      = hit_count;
         res.total_misses    = miss_count;
         res.total_evictions = eviction_count;
         owed_outcomes.push_back(res);
      endfunction

      function void compare_field(string field, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      // compare one response beat with the oldest owed outcome
      function void check_result(access_outcome_t got);
         access_outcome_t want;
         if (owed_outcomes.size() == 0) begin
            $display("%0t: response beat with no access outstanding, expected none, actual %h",
                     $time, got);
            errors++;
            return;
         end
         want = owed_outcomes.pop_front();
         compare_field("was_hit",         want.was_hit,         got.was_hit);
         compare_field("was_miss",        want.was_miss,        got.was_miss);
         compare_field("was_eviction",    want.was_eviction,    got.was_eviction);
         compare_field("extra_hit",       want.extra_hit,       got.extra_hit);
         compare_field("total_hits",      want.total_hits,      got.total_hits);
         compare_field("total_misses",    want.total_misses,    got.total_misses);
         compare_field("total_evictions", want.total_evictions, got.total_evictions);
      endfunction
   endclass

endpackage

// ===== dv/tb_set_assoc_cache_aging_lru.sv =====
module tb_set_assoc_cache_aging_lru;
   timeunit 1ns;
   timeprecision 1ps;

   import sacl_pkg::*;
   import sacl_tb_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int LONG_HOLD     = 300;
   localparam int END_SETTLE    = 16;
   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 170;

   logic clock = 1'b0;
   logic reset;
   logic no_idle      = 1'b0;
   logic hold_request = 1'b0;

   access_scoreboard board = new();

   sacl_req_if req_bus ();
   sacl_rsp_if rsp_bus ();
   sacl_csr_if csr_bus ();

   set_assoc_cache_aging_lru DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #6 clock = ~clock;

   // idle length: mostly short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [REQ_W-1:0] pick_kind();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 30) return REQ_LOAD;
      if (r < 60) return REQ_STORE;
      if (r < 90) return REQ_MODIFY;
      return REQ_UNUSED;
   endfunction

   // mostly a few tags over a few sets of the current geometry, some raw noise
   function automatic logic [ADDR_W-1:0] pick_address();
      int unsigned sb;
      int unsigned bb;
      logic [63:0] tag;
      logic [63:0] set_idx;
      logic [63:0] offset;
      logic [63:0] a;
      sb      = (board.geo_set_bits > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF
                                                        : board.geo_set_bits;
      bb      = board.geo_block_bits;
      offset  = {$urandom, $urandom};
      set_idx = $urandom_range(0, 3);
      tag     = $urandom_range(0, 5);
      case ($urandom_range(0, 9))
         0, 1: begin
            a = {$urandom, $urandom};
            return a[ADDR_W-1:0];
         end
         2: tag = {$urandom, $urandom};
         default: ;
      endcase
      a = (tag << (sb + bb)) | ((set_idx & ((64'd1 << sb) - 64'd1)) << bb)
          | (offset & ((64'd1 << bb) - 64'd1));
      return a[ADDR_W-1:0];
   endfunction

   // offer one access beat, valid stays up for a back-to-back follower
   task automatic send_access(input logic [REQ_W-1:0] kind, input logic [ADDR_W-1:0] addr);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.address  <= addr;
      do @(posedge clock); while (!req_bus.ready);
      board.note_access(kind, addr);
   endtask

   // stop offering and wait for every owed response
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (board.outstanding() > 0);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= data;
      do @(posedge clock); while (!csr_bus.ready);
      board.write_csr(idx, data);
   endtask

   // new geometry while idle, plus a write to the unmapped index
   task automatic set_geometry(input logic [5:0] sb, input logic [5:0] bb,
                               input logic [5:0] ways);
      drain();
      write_csr(CSR_SET_BITS, sb);
      write_csr(CSR_UNMAPPED, 6'($urandom));
      write_csr(CSR_BLOCK_BITS, bb);
      write_csr(CSR_WAYS, ways);
      csr_bus.valid <= 1'b0;
   endtask

   // response ready pacing, with one long hold on request
   initial begin : rsp_pacing
      int unsigned stall_left;
      int unsigned hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // response beat monitor
   always @(posedge clock) begin : rsp_monitor
      access_outcome_t got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.was_hit         = rsp_bus.was_hit;
         got.was_miss        = rsp_bus.was_miss;
         got.was_eviction    = rsp_bus.was_eviction;
         got.extra_hit       = rsp_bus.extra_hit;
         got.total_hits      = rsp_bus.total_hits;
         got.total_misses    = rsp_bus.total_misses;
         got.total_evictions = rsp_bus.total_evictions;
         board.check_result(got);
      end
   end

   // run length guard
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      req_bus.valid    <= 1'b0;
      req_bus.req_type <= REQ_LOAD;
      req_bus.address  <= '0;
      csr_bus.valid    <= 1'b0;
      csr_bus.index    <= CSR_SET_BITS;
      csr_bus.wdata    <= '0;
      reset            <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // duplicate tags in one set: two ways, then one, then two again
      set_geometry(6'd0, 6'd1, 6'd2);
      send_access(REQ_LOAD,  48'd10);
      send_access(REQ_LOAD,  48'd12);
      send_access(REQ_STORE, 48'd10);
      set_geometry(6'd0, 6'd1, 6'd1);
      send_access(REQ_LOAD,  48'd12);
      set_geometry(6'd0, 6'd1, 6'd2);
      send_access(REQ_MODIFY, 48'd12);
      send_access(REQ_LOAD,   48'd14);

      // default geometry: hit, miss, modify, unused kind, address extremes
      set_geometry(6'(SET_BITS_RST), BLOCK_BITS_RST, 6'(WAYS_RST));
      send_access(REQ_LOAD,   48'h0000_0000_0000);
      send_access(REQ_LOAD,   48'h0000_0000_0000);
      send_access(REQ_STORE,  48'h0000_0000_000F);
      send_access(REQ_MODIFY, 48'h0000_0000_0000);
      send_access(REQ_MODIFY, 48'hFFFF_FFFF_FFFF);
      send_access(REQ_UNUSED, 48'hA5A5_5A5A_A5A5);
      send_access(REQ_LOAD,   48'hFFFF_FFFF_FFFF);

      // fill set 5 and force aging evictions
      for (int t = 1; t <= 4; t++) send_access(REQ_LOAD, 48'(t << 8) | 48'h50);
      send_access(REQ_LOAD,  48'h150);
      send_access(REQ_STORE, 48'h550);
      send_access(REQ_LOAD,  48'h250);

      // wide shifts: tag and set both forced to zero
      set_geometry(6'd7, 6'd63, 6'd7);
      send_access(REQ_LOAD,   48'hFFFF_FFFF_FFFF);
      send_access(REQ_STORE,  48'h8000_0000_0000);
      send_access(REQ_MODIFY, 48'h0000_0000_0001);

      // random phases over a spread of geometries
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: set_geometry(6'd0, 6'd1, 6'd1);
            1: set_geometry(6'd6, 6'd40, 6'd4);
            2: set_geometry(6'd2, 6'd3, 6'd2);
            3: set_geometry(6'h3F, 6'd0, 6'd0);
            4: set_geometry(6'd3, 6'd63, 6'd7);
            5: set_geometry(6'd1, 6'd5, 6'd3);
            6: set_geometry(6'd5, 6'd60, 6'd5);
            default: set_geometry(6'($urandom), 6'($urandom_range(1, 12)),
                                  6'($urandom_range(0, 7)));
         endcase
         no_idle = (phase == 5 || phase == 8);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // long response hold while requests keep coming
            if (phase == 2 && i == 20) hold_request = 1'b1;
            send_access(pick_kind(), pick_address());
         end
      end
      no_idle = 1'b0;

      drain();
      repeat (END_SETTLE) @(posedge clock);
      if (board.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
